### src/mstg_pkg.sv
// Package for the multichannel sine tone generator.
// Holds shared constants, register indexes and the sine request type.
// No dependencies.
package mstg_pkg;

    // Default values for the top-level parameters.
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_PHASE_WIDTH  = 32;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_INC   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE   = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CHAN_COUNT  = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_CHANNEL = 8'd3;

    // Field widths of the registers and of the channel output field.
    localparam int PHASE_INC_W = 32;
    localparam int AMP_W       = 15;
    localparam int CCOUNT_W    = 4;
    localparam int CHAN_W      = 3;

    // Shared multiplier operand width and sine angle width.
    localparam int MUL_W   = 16;
    localparam int ANGLE_W = 16;

    // Quarter-wave polynomial coefficients (Q15 based).
    localparam logic [MUL_W-1:0] COEF_A = 16'd51472;
    localparam logic [MUL_W-1:0] COEF_B = 16'd21024;
    localparam logic [MUL_W-1:0] COEF_C = 16'd2320;

    // Request from the frame sequencer to the sine unit.
    typedef struct packed {
        logic               start;
        logic [ANGLE_W-1:0] angle;
        logic [AMP_W-1:0]   amplitude;
    } mstg_sine_req_t;

endpackage

### src/mstg_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on mstg_pkg for the operand width.
module mstg_mul
(
    input  logic                          clk,
    input  logic [mstg_pkg::MUL_W-1:0]    a,
    input  logic [mstg_pkg::MUL_W-1:0]    b,
    output logic [2*mstg_pkg::MUL_W-1:0]  p
);
    import mstg_pkg::*;

    logic [2*MUL_W-1:0] p_reg;
    logic [2*MUL_W-1:0] p_next;

    // Full-width product of the selected operands.
    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

### src/mstg_sine.sv
// Sine unit: evaluates amplitude times the quarter-wave sine polynomial
// with one shared multiplier under a small sequencer. Uses mstg_pkg, mstg_mul.
module mstg_sine
#(
    parameter int SAMPLE_WIDTH = mstg_pkg::DEF_SAMPLE_WIDTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mstg_pkg::mstg_sine_req_t    req,
    output logic                        done,
    output logic [SAMPLE_WIDTH-1:0]     sample
);
    import mstg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQ    = 3'd1;
    localparam logic [2:0] S_CUBIC = 3'd2;
    localparam logic [2:0] S_T1    = 3'd3;
    localparam logic [2:0] S_T2    = 3'd4;
    localparam logic [2:0] S_AMP   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]              state_reg, state_next;
    logic                    done_reg, done_next;
    logic [MUL_W-1:0]        x_reg, x_next;
    logic [MUL_W-1:0]        x2_reg, x2_next;
    logic [AMP_W-1:0]        amp_reg, amp_next;
    logic                    neg_reg, neg_next;
    logic [SAMPLE_WIDTH-1:0] sample_reg, sample_next;

    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [2*MUL_W-1:0]      prod;
    logic [MUL_W-1:0]        prod_q15;
    logic [14:0]             frac_fold;
    logic [SAMPLE_WIDTH+14:0] scaled;
    logic [SAMPLE_WIDTH-1:0] mag;

    mstg_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // Product shifted down by 15; every product here stays below 2^31.
    assign prod_q15 = prod[30:15];

    // Fold the angle into the first quadrant; odd quadrants mirror.
    assign frac_fold = req.angle[14] ? (15'd16384 - {1'b0, req.angle[13:0]})
                                     : {1'b0, req.angle[13:0]};

    // Scale the 15-bit magnitude to the sample width, truncating.
    assign scaled = ({{SAMPLE_WIDTH{1'b0}}, prod[29:15]} << SAMPLE_WIDTH) >> 16;
    assign mag    = scaled[SAMPLE_WIDTH-1:0];

    // Sequencer: one multiply per step.
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        x_next      = x_reg;
        x2_next     = x2_reg;
        amp_next    = amp_reg;
        neg_next    = neg_reg;
        sample_next = sample_reg;
        mul_a       = x_reg;
        mul_b       = x_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    x_next     = {frac_fold, 1'b0};
                    neg_next   = req.angle[15];
                    amp_next   = req.amplitude;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_CUBIC;
            end
            S_CUBIC:
            begin
                x2_next    = prod_q15;
                mul_a      = COEF_C;
                mul_b      = prod_q15;
                state_next = S_T1;
            end
            S_T1:
            begin
                mul_a      = x2_reg;
                mul_b      = COEF_B - prod_q15;
                state_next = S_T2;
            end
            S_T2:
            begin
                mul_a      = x_reg;
                mul_b      = COEF_A - prod_q15;
                state_next = S_AMP;
            end
            S_AMP:
            begin
                mul_a      = {1'b0, amp_reg};
                mul_b      = prod_q15;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                sample_next = neg_reg ? (~mag + 1'b1) : mag;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        x2_reg     <= x2_next;
        amp_reg    <= amp_next;
        neg_reg    <= neg_next;
        sample_reg <= sample_next;
    end

    assign done   = done_reg;
    assign sample = sample_reg;

endmodule

### src/multichannel_sine_tone_generator.sv
// Multichannel sine tone generator: a tick beat on the input stream asks for
// one interleaved frame. The block then computes one sine sample with a shared
// 16x16 multiplier over six sequencer steps, and emits one beat per channel in
// channel order, tlast on the final one. The first beat of a frame becomes
// valid once the sine unit signals done. The selected output channel
// carries amplitude times sine of the phase, all other channels carry zero,
// and a selected channel at or above the channel count gives an all-zero
// frame. The input is not ready until the last beat of the frame is taken.
// A tick beat with tick clear is taken and does nothing.
// The phase accumulator advances by phase_increment once per frame.
// Depends on mstg_pkg, mstg_sine and mstg_mul.
module multichannel_sine_tone_generator
#(
    parameter int MAX_CHANNELS = mstg_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_WIDTH = mstg_pkg::DEF_SAMPLE_WIDTH,
    parameter int PHASE_WIDTH  = mstg_pkg::DEF_PHASE_WIDTH,
    parameter int TDATA_WIDTH  = ((SAMPLE_WIDTH + mstg_pkg::CHAN_W + 7) / 8) * 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Input stream; tdata bit 0: tick.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,
    // Output stream; tdata from bit 0: sample, channel; then zero fill.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [TDATA_WIDTH-1:0]           m_axis_tdata,
    output logic                             m_axis_tlast,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mstg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mstg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mstg_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = CCOUNT_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [PHASE_WIDTH-1:0]  phase_reg, phase_next;
    logic [PHASE_INC_W-1:0]  phase_inc_reg, phase_inc_next;
    logic [AMP_W-1:0]        amp_reg, amp_next;
    logic [CCOUNT_W-1:0]     ccount_reg, ccount_next;
    logic [CHAN_W-1:0]       out_chan_reg, out_chan_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic                    valid_reg, valid_next;
    logic [SAMPLE_WIDTH-1:0] beat_sample_reg, beat_sample_next;
    logic [CHAN_W-1:0]       beat_chan_reg, beat_chan_next;
    logic                    beat_last_reg, beat_last_next;

    logic                    in_beat, out_beat, cfg_beat;
    logic [CNT_W-1:0]        eff_count;
    logic [CH_W-1:0]         last_ch;
    logic [CH_W-1:0]         load_ch;
    logic                    load_beat;
    mstg_sine_req_t          sine_req;
    logic                    sine_done;
    logic [SAMPLE_WIDTH-1:0] tone;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign cfg_beat = cfg_valid && cfg_ready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    // Effective channel count: zero reads as one, saturate at the maximum.
    always_comb
    begin
        priority if (ccount_reg == '0)
            eff_count = CNT_W'(1);
        else if (CNT_W'(ccount_reg) > CNT_W'(MAX_CHANNELS))
            eff_count = CNT_W'(MAX_CHANNELS);
        else
            eff_count = CNT_W'(ccount_reg);
    end

    assign last_ch = CH_W'(eff_count - CNT_W'(1));

    // Sine request is issued on the accepted tick with the old phase.
    assign sine_req.start     = in_beat && s_axis_tdata[0];
    assign sine_req.angle     = phase_reg[PHASE_WIDTH-1 -: ANGLE_W];
    assign sine_req.amplitude = amp_reg;

    mstg_sine #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_sine (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (sine_req),
        .done   (sine_done),
        .sample (tone)
    );

    // Configuration register writes.
    always_comb
    begin
        phase_inc_next = phase_inc_reg;
        amp_next       = amp_reg;
        ccount_next    = ccount_reg;
        out_chan_next  = out_chan_reg;
        if (cfg_beat)
        begin
            unique case (cfg_addr)
                REG_PHASE_INC:   phase_inc_next = cfg_data[PHASE_INC_W-1:0];
                REG_AMPLITUDE:   amp_next       = cfg_data[AMP_W-1:0];
                REG_CHAN_COUNT:  ccount_next    = cfg_data[CCOUNT_W-1:0];
                REG_OUT_CHANNEL: out_chan_next  = cfg_data[CHAN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Frame sequencer and output register.
    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        ch_next          = ch_reg;
        valid_next       = valid_reg;
        beat_sample_next = beat_sample_reg;
        beat_chan_next   = beat_chan_reg;
        beat_last_next   = beat_last_reg;
        load_beat        = 1'b0;
        load_ch          = ch_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sine_req.start)
                begin
                    phase_next = phase_reg + PHASE_WIDTH'(phase_inc_reg);
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (sine_done)
                begin
                    load_beat  = 1'b1;
                    load_ch    = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_beat)
                begin
                    if (ch_reg == last_ch)
                    begin
                        valid_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        load_beat = 1'b1;
                        load_ch   = ch_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Fill the output register with the beat for channel load_ch.
        if (load_beat)
        begin
            ch_next          = load_ch;
            valid_next       = 1'b1;
            beat_chan_next   = CHAN_W'(load_ch);
            beat_last_next   = (load_ch == last_ch);
            beat_sample_next = (CNT_W'(load_ch) == CNT_W'(out_chan_reg)) ? tone : '0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            phase_inc_reg <= '0;
            amp_reg       <= '0;
            ccount_reg    <= CCOUNT_W'(1);
            out_chan_reg  <= '0;
            ch_reg        <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            phase_inc_reg <= phase_inc_next;
            amp_reg       <= amp_next;
            ccount_reg    <= ccount_next;
            out_chan_reg  <= out_chan_next;
            ch_reg        <= ch_next;
            valid_reg     <= valid_next;
        end
    end

    // Beat payload.
    always_ff @(posedge clk)
    begin
        beat_sample_reg <= beat_sample_next;
        beat_chan_reg   <= beat_chan_next;
        beat_last_reg   <= beat_last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = beat_last_reg;
    assign m_axis_tdata  = TDATA_WIDTH'({beat_chan_reg, beat_sample_reg});

endmodule

### test/tb.sv
// Self-checking testbench for the multichannel sine tone generator.
// Drives tick beats and register writes, predicts every frame, checks each output beat.
// Depends on mstg_pkg and multichannel_sine_tone_generator.
`timescale 1ns / 100ps

module tb;

    import mstg_pkg::*;

    localparam int OUT_TDATA_W = ((DEF_SAMPLE_WIDTH + CHAN_W + 7) / 8) * 8;
    localparam int MAX_CH      = DEF_MAX_CHANNELS;
    localparam int ITEM_TARGET = 330;
    // Cycles to let a frame in flight drain before a register write.
    localparam int SETTLE      = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_LO = 8'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_HI = 8'hFF;

    typedef enum logic [1:0] {ROW_CFG, ROW_IDLE, ROW_FRAME} row_kind_t;
    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_LONG} rx_mode_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [31:0]           value;
        bit                    fixed;
        logic signed [15:0]    tone;
    } script_row_t;

    typedef struct {
        logic signed [15:0] sample;
        logic [2:0]         chan;
        logic               last;
    } tone_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow copy of the registers and the phase accumulator.
    logic [31:0] cfg_phase_inc = '0;
    logic [14:0] cfg_amp = '0;
    logic [3:0]  cfg_ccount = 4'd1;
    logic [2:0]  cfg_out_chan = '0;
    logic [31:0] tone_phase = '0;

    tone_beat_t pending_beats [$];

    int unsigned items_sent = 0;
    int unsigned frames_sent = 0;
    int unsigned beats_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit          busy = 1'b0;

    rx_mode_t    rx_mode = RX_ALWAYS;
    int unsigned rx_left = 0;
    int unsigned rx_tick = 0;

    // Directed rows: reset state, quarter-turn extremes, channel count and selection cases.
    localparam int SCRIPT_LEN = 37;
    script_row_t script [SCRIPT_LEN] = '{
        '{ROW_FRAME, '0, '0, 1'b1, 16'sd0},
        '{ROW_IDLE,  '0, '0, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_AMPLITUDE, 32'd32767, 1'b0, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b1, 16'sd0},
        '{ROW_CFG,   REG_PHASE_INC, 32'h4000_0000, 1'b0, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b1, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b1, 16'sd32767},
        '{ROW_FRAME, '0, '0, 1'b1, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b1, -16'sd32767},
        '{ROW_IDLE,  '0, '0, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_CHAN_COUNT, 32'd8, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_OUT_CHANNEL, 32'd7, 1'b0, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b1, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b1, 16'sd32767},
        '{ROW_CFG,   REG_CHAN_COUNT, 32'd0, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_OUT_CHANNEL, 32'd0, 1'b0, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b1, 16'sd0},
        '{ROW_CFG,   REG_CHAN_COUNT, 32'd15, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_OUT_CHANNEL, 32'd3, 1'b0, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b1, -16'sd32767},
        '{ROW_CFG,   REG_CHAN_COUNT, 32'd4, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_OUT_CHANNEL, 32'd5, 1'b0, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b1, 16'sd0},
        '{ROW_CFG,   REG_UNUSED_LO, 32'hFFFF_FFFF, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_UNUSED_HI, 32'h5A5A_5A5A, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_PHASE_INC, 32'hFFFF_FFFF, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_AMPLITUDE, 32'hFFFF_FFFF, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_CHAN_COUNT, 32'hFFFF_FFFF, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_OUT_CHANNEL, 32'hFFFF_FFF8, 1'b0, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b0, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b0, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_AMPLITUDE, 32'd1, 1'b0, 16'sd0},
        '{ROW_CFG,   REG_PHASE_INC, 32'h0123_4567, 1'b0, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b0, 16'sd0},
        '{ROW_IDLE,  '0, '0, 1'b0, 16'sd0},
        '{ROW_FRAME, '0, '0, 1'b0, 16'sd0}
    };

    multichannel_sine_tone_generator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Fixed-point sine of the phase scaled by the amplitude, Q1.15.
    function automatic logic signed [15:0] tone_q15(input logic [31:0] ph,
                                                    input logic [14:0] amp);
        logic [15:0] angle;
        logic [1:0]  quad;
        logic [47:0] frac;
        logic [47:0] x;
        logic [47:0] x2;
        logic [47:0] t;
        logic [47:0] y;
        logic [47:0] m;
        angle = ph[31:16];
        quad  = angle[15:14];
        frac  = 48'(angle[13:0]);
        // Odd quadrants run the quarter wave backwards.
        if (quad[0])
        begin
            frac = 48'd16384 - frac;
        end
        x  = frac << 1;
        x2 = (x * x) >> 15;
        t  = 48'(COEF_B) - ((48'(COEF_C) * x2) >> 15);
        t  = 48'(COEF_A) - ((x2 * t) >> 15);
        y  = (x * t) >> 15;
        m  = (48'(amp) * y) >> 15;
        return quad[1] ? -m[15:0] : m[15:0];
    endfunction

    // Queue the beats of one frame and advance the accumulator.
    task automatic predict_frame(input bit fixed, input logic signed [15:0] fixed_tone);
        int unsigned        n;
        logic signed [15:0] tone;
        tone_beat_t         b;
        n = (cfg_ccount == 0) ? 1 : (cfg_ccount > MAX_CH) ? MAX_CH : int'(cfg_ccount);
        tone = fixed ? fixed_tone : tone_q15(tone_phase, cfg_amp);
        for (int j = 0; j < n; j++)
        begin
            b.sample = (j == int'(cfg_out_chan)) ? tone : 16'sd0;
            b.chan   = 3'(j);
            b.last   = (j == n - 1);
            pending_beats.push_back(b);
        end
        tone_phase = tone_phase + cfg_phase_inc;
        frames_sent++;
    endtask

    // One tick beat, sent in bursts with random gaps. Called and left at a falling edge.
    task automatic send_tick(input bit tick_val, input bit fixed,
                             input logic signed [15:0] fixed_tone);
        if (burst_left == 0)
        begin
            s_axis_tvalid = 1'b0;
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(10, 30)) @(negedge clk);
            end
            else
            begin
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'd0, tick_val};
        do @(posedge clk); while (!s_axis_tready);
        if (tick_val)
        begin
            predict_frame(fixed, fixed_tone);
        end
        items_sent++;
        burst_left--;
        busy = 1'b1;
        @(negedge clk);
    endtask

    // Let every expected beat arrive and the block settle before touching registers.
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        if (busy)
        begin
            while (pending_beats.size() != 0) @(posedge clk);
            repeat (SETTLE) @(posedge clk);
            @(negedge clk);
            busy = 1'b0;
        end
    endtask

    // Register write on the configuration channel; shadow copy follows on acceptance.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_addr  = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_PHASE_INC:   cfg_phase_inc = value;
            REG_AMPLITUDE:   cfg_amp       = value[AMP_W-1:0];
            REG_CHAN_COUNT:  cfg_ccount    = value[CCOUNT_W-1:0];
            REG_OUT_CHANNEL: cfg_out_chan  = value[CHAN_W-1:0];
            default:         ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver readiness: switches between several stall patterns.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_ALWAYS: m_axis_tready = 1'b1;
            RX_RANDOM: m_axis_tready = ($urandom_range(0, 1) == 1);
            RX_SPARSE: m_axis_tready = (rx_tick % 4 != 0);
            default:   m_axis_tready = (rx_tick % 16 >= 12);
        endcase
    end

    // Output checker: each accepted beat against the oldest expectation.
    always @(posedge clk)
    begin
        tone_beat_t b;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected output beat: sample %0d channel %0d",
                       $signed(m_axis_tdata[15:0]), m_axis_tdata[18:16]);
                mismatches++;
            end
            else
            begin
                b = pending_beats.pop_front();
                beats_checked++;
                if (m_axis_tdata[15:0] !== b.sample)
                begin
                    $error("sample mismatch: expected %0d, actual %0d",
                           b.sample, $signed(m_axis_tdata[15:0]));
                    mismatches++;
                end
                if (m_axis_tdata[18:16] !== b.chan)
                begin
                    $error("channel mismatch: expected %0d, actual %0d",
                           b.chan, m_axis_tdata[18:16]);
                    mismatches++;
                end
                if (m_axis_tlast !== b.last)
                begin
                    $error("last_in_frame mismatch: expected %0d, actual %0d",
                           b.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d beats still expected.",
                     cycle_count, pending_beats.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] data;
        logic [3:0]  ccount;
        int unsigned eff;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part.
        foreach (script[i])
        begin
            case (script[i].kind)
                ROW_CFG:
                begin
                    wait_idle();
                    write_reg(script[i].addr, script[i].value);
                end
                ROW_IDLE:  send_tick(1'b0, 1'b0, 16'sd0);
                default:   send_tick(1'b1, script[i].fixed, script[i].tone);
            endcase
        end

        // Random part: a new setting per phase, then a run of ticks.
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 4))
                    0:       data = 32'd0;
                    1:       data = 32'hFFFF_FFFF;
                    2:       data = $urandom_range(1, 255);
                    default: data = $urandom();
                endcase
                write_reg(REG_PHASE_INC, data);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                data = $urandom();
                case ($urandom_range(0, 3))
                    0:       data[14:0] = '0;
                    1:       data[14:0] = '1;
                    default: ;
                endcase
                write_reg(REG_AMPLITUDE, data);
            end
            ccount = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(1, 8));
            data = $urandom();
            data[3:0] = ccount;
            write_reg(REG_CHAN_COUNT, data);
            eff = (ccount == 0) ? 1 : (ccount > MAX_CH) ? MAX_CH : int'(ccount);
            data = $urandom();
            data[2:0] = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                    : 3'($urandom_range(0, eff - 1));
            write_reg(REG_OUT_CHANNEL, data);
            if ($urandom_range(0, 5) == 0)
            begin
                write_reg(REG_UNUSED_LO + 8'($urandom_range(0, 251)), $urandom());
            end
            repeat ($urandom_range(16, 32))
            begin
                send_tick($urandom_range(0, 9) != 0, 1'b0, 16'sd0);
            end
        end

        // Drain and report.
        wait_idle();
        $display("Sent %0d tick beats (%0d frames) with %0d register writes.",
                 items_sent, frames_sent, reg_writes);
        $display("Checked %0d output beats, %0d mismatches.", beats_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
